[sv/sstg_pkg.sv]
// Shared types, constants and helpers of the stacked square tone generator.
`timescale 1ns / 1ps
`default_nettype none

package sstg_pkg;

   localparam int NUM_GROUPS     = 4;
   localparam int SUBS_PER_GROUP = 4;
   localparam int NUM_CHANNELS   = 16;
   localparam int PERIOD_BITS    = 16;

   localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W     = $clog2(NUM_CHANNELS + 1);
   localparam int BEND_W    = 16;
   localparam int BEND_FRAC = 14;
   localparam int PROD_W    = PERIOD_BITS + BEND_W;
   localparam int PIN_W     = 16;
   localparam int VEL_STEP  = 127 / SUBS_PER_GROUP;

   localparam logic [BEND_W-1:0] UNITY_BEND = 16'd16384;

   // item codes
   localparam logic [2:0] FUNC_TICK     = 3'd0;
   localparam logic [2:0] FUNC_NOTE_ON  = 3'd1;
   localparam logic [2:0] FUNC_NOTE_OFF = 3'd2;
   localparam logic [2:0] FUNC_BEND     = 3'd3;
   localparam logic [2:0] FUNC_STOP_ALL = 3'd4;

   typedef struct packed {
      logic [2:0]  func;
      logic [1:0]  group_index;
      logic [6:0]  note_number;
      logic [6:0]  velocity;
      logic [15:0] base_period;
      logic [3:0]  channel_index;
      logic [15:0] bend_scale;
   } req_type;

   typedef struct packed {
      logic [15:0] pin_levels;
      logic        note_matched;
   } rsp_type;

   // one channel's word in the state RAM
   typedef struct packed {
      logic [BEND_W-1:0]      bend;
      logic [PERIOD_BITS-1:0] counter;
      logic [PERIOD_BITS-1:0] active;
      logic [PERIOD_BITS-1:0] base;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam entry_type RESET_ENTRY = '{
      bend:    UNITY_BEND,
      counter: '0,
      active:  '0,
      base:    '0
   };

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] base_in;
      logic [15:0] bend_in;
   } alu_ctrl_type;

   typedef struct packed {
      entry_type entry;
      logic      pin;
   } alu_out_type;

   typedef struct packed {
      logic        active;
      logic [6:0]  note;
   } group_note_type;

   function automatic logic [PERIOD_BITS-1:0] sat_period(input logic [PROD_W-1:0] v);
      logic [PERIOD_BITS-1:0] r;
      if (v[PROD_W-1:PERIOD_BITS] != '0) begin
         r = '1;
      end else begin
         r = v[PERIOD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/stacked_square_tone_generator_core.sv]
// Top level: stacked square tone generator with per-channel state in one RAM.
//
//   channel   ports                         direction  transfer when
//   request   start, busy, req_data         in         start && !busy at a rising edge
//   response  rsp_strobe, rsp_data          out        rsp_strobe high (one cycle)
//
// Walk: a tick walks every channel, one RAM read per cycle with the
//   write-back in the cycle after; a new transfer is taken only once the walk
//   is done. A note on walks the channels it starts, a matching note off the
//   group's channels, a bend one channel, other items none.
//   The walk is paced by the single read port of the channel state RAM.
// Reset: synchronous, active high; state reads back as its reset value at once
//   (per-entry valid bits), so no clearing pass is needed. Stop all does the same.
// Stalls: the receiver cannot stall; every response is a single-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module stacked_square_tone_generator_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire sstg_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output sstg_pkg::rsp_type      rsp_data
);

   import sstg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   req_type req_ff, req_in;

   // walk control: read side leads, write side trails by the RAM latency
   logic [CH_W-1:0]  rd_ch_ff, rd_ch_in;
   logic [CNT_W-1:0] rd_left_ff, rd_left_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [CH_W-1:0]  wr_ch_ff, wr_ch_in;

   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;
   logic [NUM_CHANNELS-1:0] pins_ff, pins_in;
   group_note_type          group_note_ff [NUM_GROUPS];
   group_note_type          group_note_in [NUM_GROUPS];
   logic                    matched_ff, matched_in;

   logic             accept;
   logic             rd_en;
   logic [ENTRY_W-1:0] rd_word;
   entry_type        entry_cur;
   alu_ctrl_type     alu_ctrl;
   alu_out_type      alu_res;

   logic [CNT_W-1:0] on_count;
   logic             grp_ok;
   logic             off_match;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // how many stacked channels a note on reaches (velocity and range both monotonic)
   always_comb begin
      on_count = '0;
      for (int i = 0; i < SUBS_PER_GROUP; i++) begin
         if ((int'(req_data.velocity) >= VEL_STEP * i) &&
             (int'(req_data.group_index) * SUBS_PER_GROUP + i < NUM_CHANNELS) &&
             (on_count == CNT_W'(i))) begin
            on_count = CNT_W'(i + 1);
         end
      end
   end

   assign grp_ok    = (int'(req_data.group_index) < NUM_GROUPS);
   assign off_match = grp_ok && group_note_ff[req_data.group_index].active &&
                      (group_note_ff[req_data.group_index].note == req_data.note_number);

   // channel state RAM
   assign rd_en = (state_ff == ST_RUN) && (rd_left_ff != '0);

   sstg_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (wr_pend_ff),
      .wr_addr (wr_ch_ff),
      .wr_data (alu_res.entry),
      .rd_en   (rd_en),
      .rd_addr (rd_ch_ff),
      .rd_data (rd_word)
   );

   // never-written entries read as their reset value
   assign entry_cur = valid_ff[wr_ch_ff] ? entry_type'(rd_word) : RESET_ENTRY;

   assign alu_ctrl.func    = req_ff.func;
   assign alu_ctrl.base_in = req_ff.base_period;
   assign alu_ctrl.bend_in = req_ff.bend_scale;

   sstg_chan_alu u_alu (
      .ctrl      (alu_ctrl),
      .entry_cur (entry_cur),
      .pin_cur   (pins_ff[wr_ch_ff]),
      .result    (alu_res)
   );

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      rd_ch_in   = rd_ch_ff;
      rd_left_in = rd_left_ff;
      wr_pend_in = 1'b0;
      wr_ch_in   = wr_ch_ff;
      valid_in   = valid_ff;
      pins_in    = pins_ff;
      matched_in = matched_ff;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_note_in[g] = group_note_ff[g];
      end

      // trailing write-back of the walk
      if (wr_pend_ff) begin
         valid_in[wr_ch_ff] = 1'b1;
         pins_in[wr_ch_ff]  = alu_res.pin;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               matched_in = 1'b0;
               rd_left_in = '0;
               rd_ch_in   = '0;
               state_in   = ST_RUN;
               case (req_data.func)
                  FUNC_TICK: begin
                     rd_left_in = CNT_W'(NUM_CHANNELS);
                  end
                  FUNC_NOTE_ON: begin
                     if (grp_ok) begin
                        group_note_in[req_data.group_index] = '{active: 1'b1,
                                                               note: req_data.note_number};
                        rd_ch_in   = CH_W'(int'(req_data.group_index) * SUBS_PER_GROUP);
                        rd_left_in = on_count;
                     end
                  end
                  FUNC_NOTE_OFF: begin
                     if (off_match) begin
                        group_note_in[req_data.group_index] = '0;
                        matched_in = 1'b1;
                        rd_ch_in   = CH_W'(int'(req_data.group_index) * SUBS_PER_GROUP);
                        // group channels that exist
                        for (int i = 0; i < SUBS_PER_GROUP; i++) begin
                           if (int'(req_data.group_index) * SUBS_PER_GROUP + i
                               < NUM_CHANNELS) begin
                              rd_left_in = CNT_W'(i + 1);
                           end
                        end
                     end
                  end
                  FUNC_BEND: begin
                     if (int'(req_data.channel_index) < NUM_CHANNELS) begin
                        rd_ch_in   = CH_W'(req_data.channel_index);
                        rd_left_in = CNT_W'(1);
                     end
                  end
                  FUNC_STOP_ALL: begin
                     valid_in = '0;
                     pins_in  = '0;
                     for (int g = 0; g < NUM_GROUPS; g++) begin
                        group_note_in[g] = '0;
                     end
                  end
                  default: begin
                     rd_left_in = '0;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (rd_left_ff != '0) begin
               rd_ch_in   = rd_ch_ff + 1'b1;
               rd_left_in = rd_left_ff - 1'b1;
               wr_pend_in = 1'b1;
               wr_ch_in   = rd_ch_ff;
            end else begin
               // last write-back lands this cycle, pins settle for DONE
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_left_ff <= '0;
         wr_pend_ff <= 1'b0;
         valid_ff   <= '0;
         pins_ff    <= '0;
         matched_ff <= 1'b0;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_note_ff[g] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         rd_left_ff <= rd_left_in;
         wr_pend_ff <= wr_pend_in;
         valid_ff   <= valid_in;
         pins_ff    <= pins_in;
         matched_ff <= matched_in;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_note_ff[g] <= group_note_in[g];
         end
      end
   end

   // payload and walk pointers need no reset
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rd_ch_ff <= rd_ch_in;
      wr_ch_ff <= wr_ch_in;
   end

   // response: one-cycle strobe straight from registers
   assign rsp_strobe = (state_ff == ST_DONE);

   always_comb begin
      rsp_data.pin_levels   = '0;
      rsp_data.note_matched = matched_ff;
      for (int i = 0; i < PIN_W; i++) begin
         if (i < NUM_CHANNELS) begin
            rsp_data.pin_levels[i] = pins_ff[i];
         end
      end
   end

   // read and write-back of the walk never touch the same entry together
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_pend_ff) |-> (rd_ch_ff != wr_ch_ff))
      else $error("RAM read and write-back address clash");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   a_match_only_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.note_matched) |-> (req_ff.func == FUNC_NOTE_OFF))
      else $error("note match reported for an item that is not a note off");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> ((rd_left_ff == '0) && !wr_pend_ff))
      else $error("walk still pending while idle");

endmodule

`default_nettype wire

[sv/sstg_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sstg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/sstg_chan_alu.sv]
// Per-channel update: tick, note on, note off and bend applied to one RAM word.
`timescale 1ns / 1ps
`default_nettype none

module sstg_chan_alu (
   input  wire sstg_pkg::alu_ctrl_type ctrl,
   input  wire sstg_pkg::entry_type    entry_cur,
   input  wire logic                   pin_cur,
   output sstg_pkg::alu_out_type       result
);

   import sstg_pkg::*;

   logic [PERIOD_BITS-1:0] base_sat;
   logic [PERIOD_BITS-1:0] mul_a;
   logic [BEND_W-1:0]      mul_b;
   logic [PROD_W-1:0]      product;
   logic [PERIOD_BITS-1:0] scaled;

   assign base_sat = sat_period(PROD_W'(ctrl.base_in));

   // one shared multiplier: note on uses the new base, bend the new factor
   assign mul_a   = (ctrl.func == FUNC_NOTE_ON) ? base_sat : entry_cur.base;
   assign mul_b   = (ctrl.func == FUNC_NOTE_ON) ? entry_cur.bend : ctrl.bend_in;
   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign scaled  = sat_period(product >> BEND_FRAC);

   always_comb begin
      result.entry = entry_cur;
      result.pin   = pin_cur;
      case (ctrl.func)
         FUNC_TICK: begin
            if (entry_cur.active != '0) begin
               if (entry_cur.counter >= entry_cur.active) begin
                  result.pin           = ~pin_cur;
                  result.entry.counter = '0;
               end else begin
                  result.entry.counter = entry_cur.counter + 1'b1;
               end
            end
         end
         FUNC_NOTE_ON: begin
            result.entry.base   = base_sat;
            result.entry.active = scaled;
         end
         FUNC_NOTE_OFF: begin
            result.entry.base   = '0;
            result.entry.active = '0;
            result.pin          = 1'b0;
         end
         FUNC_BEND: begin
            result.entry.bend = ctrl.bend_in;
            if (entry_cur.base != '0) begin
               result.entry.active = scaled;
            end
         end
         default: begin
            result.entry = entry_cur;
         end
      endcase
   end

endmodule

`default_nettype wire

[tb/tone_checker.sv]
// Checker for the stacked square tone generator: predicts pin levels and compares responses.
`timescale 1ns / 1ps

module tone_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire sstg_pkg::req_type req_data,
   input  wire logic              rsp_strobe,
   input  wire sstg_pkg::rsp_type rsp_data,
   output int                     mismatch_count,
   output int                     outstanding
);

   import sstg_pkg::*;

   // voice state as seen from outside
   group_note_type         group_state [NUM_GROUPS];
   logic [PERIOD_BITS-1:0] base_len    [NUM_CHANNELS];
   logic [PERIOD_BITS-1:0] half_period [NUM_CHANNELS];
   logic [PERIOD_BITS-1:0] tick_count  [NUM_CHANNELS];
   logic [15:0]            bend_ratio  [NUM_CHANNELS];
   logic                   pin_level   [NUM_CHANNELS];

   rsp_type expected_pins [$];
   rsp_type due;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // floor(base * ratio / 2^14), clipped to the period width
   function automatic logic [PERIOD_BITS-1:0] bent_period(input logic [PERIOD_BITS-1:0] b,
                                                          input logic [15:0] ratio);
      logic [47:0] prod;
      prod = ({32'd0, b} * {32'd0, ratio}) >> 14;
      return (prod > 48'(2**PERIOD_BITS - 1)) ? '1 : prod[PERIOD_BITS-1:0];
   endfunction

   function automatic void clear_voices();
      for (int g = 0; g < NUM_GROUPS; g++) group_state[g] = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         base_len[c]    = '0;
         half_period[c] = '0;
         tick_count[c]  = '0;
         bend_ratio[c]  = UNITY_BEND;
         pin_level[c]   = 1'b0;
      end
   endfunction

   // apply one transfer to the voice state and return the expected response
   function automatic rsp_type advance_voices(input req_type r);
      rsp_type res;
      int      grp;
      int      ch;
      res = '0;
      grp = int'(r.group_index);
      case (r.func)
         FUNC_TICK: begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (half_period[c] != '0) begin
                  if (tick_count[c] >= half_period[c]) begin
                     pin_level[c]  = ~pin_level[c];
                     tick_count[c] = '0;
                  end else begin
                     tick_count[c] = tick_count[c] + 1'b1;
                  end
               end
            end
         end
         FUNC_NOTE_ON: begin
            if (grp < NUM_GROUPS) begin
               group_state[grp] = '{active: 1'b1, note: r.note_number};
               // velocity threshold rises with the stack position
               for (int i = 0; i < SUBS_PER_GROUP; i++) begin
                  ch = grp * SUBS_PER_GROUP + i;
                  if (int'(r.velocity) >= VEL_STEP * i && ch < NUM_CHANNELS) begin
                     base_len[ch]    = r.base_period;
                     half_period[ch] = bent_period(r.base_period, bend_ratio[ch]);
                  end
               end
            end
         end
         FUNC_NOTE_OFF: begin
            if (grp < NUM_GROUPS && group_state[grp].active &&
                group_state[grp].note == r.note_number) begin
               group_state[grp] = '0;
               res.note_matched = 1'b1;
               for (int i = 0; i < SUBS_PER_GROUP; i++) begin
                  ch = grp * SUBS_PER_GROUP + i;
                  if (ch < NUM_CHANNELS) begin
                     base_len[ch]    = '0;
                     half_period[ch] = '0;
                     pin_level[ch]   = 1'b0;
                  end
               end
            end
         end
         FUNC_BEND: begin
            ch = int'(r.channel_index);
            if (ch < NUM_CHANNELS) begin
               bend_ratio[ch] = r.bend_scale;
               if (base_len[ch] != '0) half_period[ch] = bent_period(base_len[ch], r.bend_scale);
            end
         end
         FUNC_STOP_ALL: clear_voices();
         default: ;
      endcase
      for (int c = 0; c < NUM_CHANNELS && c < PIN_W; c++) res.pin_levels[c] = pin_level[c];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_voices();
         expected_pins.delete();
      end else begin
         if (start && !busy) expected_pins.push_back(advance_voices(req_data));
         if (rsp_strobe) begin
            if (expected_pins.size() == 0) begin
               report_mismatch($sformatf("response %h with nothing outstanding", rsp_data));
            end else begin
               due = expected_pins.pop_front();
               if (rsp_data.pin_levels !== due.pin_levels)
                  report_mismatch($sformatf("pin_levels expected %h got %h",
                                            due.pin_levels, rsp_data.pin_levels));
               if (rsp_data.note_matched !== due.note_matched)
                  report_mismatch($sformatf("note_matched expected %b got %b",
                                            due.note_matched, rsp_data.note_matched));
            end
         end
      end
      outstanding <= expected_pins.size();
   end

endmodule

[tb/testbench.sv]
// Top of the tone generator testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
   import sstg_pkg::*;

   // generous bound: ~950 transfers with their busy time plus sender gaps
   localparam int CYCLE_LIMIT  = 400000;
   // longest item is a tick, which walks every channel, so this covers the tail
   localparam int DRAIN_CYCLES = 4 * (NUM_CHANNELS + 3);
   localparam int PHASE_ITEMS  = 300;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int mismatch_count;
   int outstanding;
   int cycle_count = 0;
   int sender_idle_pct = 0;

   // stimulus-side memory of the notes held, so that note offs can match
   logic [6:0] held_note [NUM_GROUPS];
   logic       held_on   [NUM_GROUPS];

   always #5 clock = ~clock;

   stacked_square_tone_generator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   tone_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // One transfer. Random idle cycles are put in front with start low; when none
   // are drawn, start simply stays high from the previous transfer, so it is
   // never lowered and raised within the same step.
   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      // busy read here is the value from before the edge
      while (busy) @(posedge clock);
   endtask

   function automatic req_type make_item(input logic [2:0] func, input int grp, input int note,
                                         input int vel, input int base, input int chan,
                                         input int bend);
      req_type r;
      r.func          = func;
      r.group_index   = grp[1:0];
      r.note_number   = note[6:0];
      r.velocity      = vel[6:0];
      r.base_period   = base[15:0];
      r.channel_index = chan[3:0];
      r.bend_scale    = bend[15:0];
      return r;
   endfunction

   // Mostly musical traffic with random content: frequent ticks, short periods
   // so that pins really toggle, note offs that usually hit the held note.
   // Fields that the operation ignores still carry random bits.
   function automatic req_type next_random_item();
      req_type r;
      int      pick;
      int      grp;
      r.func          = 3'($urandom);
      r.group_index   = 2'($urandom);
      r.note_number   = 7'($urandom);
      r.velocity      = 7'($urandom);
      r.base_period   = 16'($urandom);
      r.channel_index = 4'($urandom);
      r.bend_scale    = 16'($urandom);
      grp  = int'(r.group_index);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.func = FUNC_TICK;
      end else if (pick < 65) begin
         r.func = FUNC_NOTE_ON;
         pick   = $urandom_range(0, 9);
         if (pick < 8) r.base_period = 16'($urandom_range(1, 6));
         else if (pick == 8) r.base_period = '0;
         held_note[grp] = r.note_number;
         held_on[grp]   = 1'b1;
      end else if (pick < 78) begin
         r.func = FUNC_NOTE_OFF;
         if (held_on[grp] && $urandom_range(0, 9) < 7) begin
            r.note_number = held_note[grp];
            held_on[grp]  = 1'b0;
         end
      end else if (pick < 88) begin
         r.func = FUNC_BEND;
         pick   = $urandom_range(0, 3);
         if (pick < 2) r.bend_scale = 16'($urandom_range(8192, 32768));
         else if (pick == 2) r.bend_scale = UNITY_BEND;
      end else if (pick < 90) begin
         r.func = FUNC_STOP_ALL;
         for (int g = 0; g < NUM_GROUPS; g++) held_on[g] = 1'b0;
      end
      // the rest is noise: any func code, unknown ones included, random fields
      return r;
   endfunction

   initial begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         held_note[g] = '0;
         held_on[g]   = 1'b0;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part, no idling ---
      send_item(make_item(FUNC_TICK, 0, 0, 0, 0, 0, 0));             // tick with all silent
      send_item(make_item(FUNC_NOTE_ON, 0, 60, 0, 1, 0, 0));         // zero velocity: channel 0 only
      repeat (3) send_item(make_item(FUNC_TICK, 3, 127, 127, 65535, 15, 65535));
      send_item(make_item(FUNC_NOTE_ON, 1, 127, 127, 2, 0, 0));      // full stack
      send_item(make_item(FUNC_NOTE_ON, 2, 1, 31, 0, 0, 0));         // zero period stays silent
      send_item(make_item(FUNC_BEND, 0, 0, 0, 0, 4, 0));             // bend to zero silences
      send_item(make_item(FUNC_BEND, 0, 0, 0, 0, 5, 65535));         // largest bend
      send_item(make_item(FUNC_BEND, 0, 0, 0, 0, 12, 32768));        // bend with no note held
      send_item(make_item(FUNC_NOTE_ON, 3, 0, 62, 65535, 0, 0));     // saturating period
      send_item(make_item(FUNC_NOTE_ON, 3, 5, 93, 3, 0, 0));         // note on while active
      repeat (4) send_item(make_item(FUNC_TICK, 0, 0, 0, 0, 0, 0));
      send_item(make_item(FUNC_NOTE_OFF, 1, 126, 0, 0, 0, 0));       // wrong note
      send_item(make_item(FUNC_NOTE_OFF, 0, 60, 0, 0, 0, 0));        // match clears the pin
      send_item(make_item(FUNC_NOTE_OFF, 0, 60, 0, 0, 0, 0));        // group now inactive
      send_item(make_item(3'd5, 1, 2, 3, 4, 5, 6));                  // unknown codes
      send_item(make_item(3'd6, 2, 3, 4, 5, 6, 7));
      send_item(make_item(3'd7, 3, 127, 127, 65535, 15, 65535));
      send_item(make_item(FUNC_TICK, 0, 0, 0, 0, 0, 0));
      send_item(make_item(FUNC_STOP_ALL, 0, 0, 0, 0, 0, 0));
      send_item(make_item(FUNC_TICK, 0, 0, 0, 0, 0, 0));

      // --- random part: sender idles 30 %, then 53 %, then never ---
      sender_idle_pct = 30;
      repeat (PHASE_ITEMS) send_item(next_random_item());
      sender_idle_pct = 53;
      repeat (PHASE_ITEMS) send_item(next_random_item());
      sender_idle_pct = 0;
      repeat (PHASE_ITEMS) send_item(next_random_item());
      start <= 1'b0;

      // let the checker register the last transfer, then drain
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
